>>> rtl/msamp_pkg.sv
// msamp_pkg: shared types, constants and helpers of the mipmap texture sampler
// used by the front, back and top files of the sampler; depends on nothing
package msamp_pkg;

  localparam int MAX_LEVELS   = 8;
  localparam int CHANNEL_BITS = 16;
  localparam int KW           = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH    = 4;
  localparam int IW           = 3;
  localparam int NSTAGE       = 12;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_FILTER_MODE = 2'd0;
  localparam logic [1:0] REG_LOD_BIAS    = 2'd1;
  localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

  typedef struct packed {
    logic               op;
    logic        [2:0]  write_level;
    logic        [6:0]  texel_x;
    logic        [6:0]  texel_y;
    logic        [47:0] texel_word;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] du_u;
    logic signed [31:0] du_v;
    logic signed [31:0] dv_u;
    logic signed [31:0] dv_v;
  } item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        used_finest;
  } result_t;

  typedef struct packed {
    logic               filter_mode;
    logic signed [11:0] lod_bias;
    logic        [3:0]  level_count;
  } cfg_t;

  typedef struct packed {
    logic          op;
    logic          wr_ok;
    logic [2:0]    wlev;
    logic [6:0]    x;
    logic [6:0]    y;
    logic [47:0]   word;
    logic [31:0]   u;
    logic [31:0]   v;
    logic [KW-1:0] k0;
    logic [KW-1:0] k1;
    logic [7:0]    frac;
    logic          used;
  } qitem_t;

  typedef struct packed {
    logic [IW-1:0] inflight;
  } bstat_t;

  // first texel of level k: sum of 4^i below k
  function automatic logic [31:0] lvl_base(input logic [KW-1:0] k);
    logic [31:0] b;
    b = 32'd0;
    for (int i = 0; i < 12; i++) begin
      if (i < int'(k)) b = b + (32'd1 << (2 * i));
    end
    return b;
  endfunction

endpackage

>>> rtl/msamp_fifo.sv
// msamp_fifo: small register queue of words of any packed type
// used between the front and back parts and for results; depends on nothing
module msamp_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  input  logic pop,
  output T     rdata,
  output logic full,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [CNW-1:0] count;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end
endmodule

>>> rtl/msamp_front.sv
// msamp_front: accepts words, works out the level of detail of samples in a
// pipeline and classifies them into queue entries; depends on msamp_pkg
module msamp_front #(
  parameter int MAX_LEVELS = msamp_pkg::MAX_LEVELS
) (
  input  logic              clk,
  input  logic              rst,
  input  msamp_pkg::item_t  item,
  input  logic              item_valid,
  output logic              item_stall,
  input  msamp_pkg::cfg_t   cfg,
  output msamp_pkg::qitem_t qd,
  output logic              q_push,
  input  logic              q_full
);
  localparam int NS = msamp_pkg::NSTAGE;
  localparam int KW = msamp_pkg::KW;

  typedef struct packed {
    logic        op;
    logic [2:0]  wlev;
    logic [6:0]  x;
    logic [6:0]  y;
    logic [47:0] word;
    logic [31:0] u;
    logic [31:0] v;
    logic        dzero;
  } carry_t;

  function automatic logic [31:0] mag32(input logic [31:0] r);
    return r[31] ? (~r + 32'd1) : r;
  endfunction

  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] p;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

  logic [NS-1:0] pv;
  carry_t        car [NS];
  logic [31:0]   d0 [4];
  logic [63:0]   sq [4];
  logic [63:0]   s2r, s3;
  logic [7:0]    gnz;
  logic [2:0]    gpos [8];
  logic [5:0]    n4;
  logic [31:0]   m4;
  logic [31:0]   lm [7];
  logic [6:0]    lb [7];
  logic [5:0]    ln [7];
  logic          advance;

  assign advance    = !pv[NS-1] || !q_full;
  assign item_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else if (advance) begin
      pv <= {pv[NS-2:0], item_valid};
    end
  end

  // stage 0 to 3: capture, squares, larger length, byte leading ones
  logic [63:0] s1, s2, smax;
  always_comb begin
    s1   = sq[0] + sq[1];
    s2   = sq[2] + sq[3];
    smax = (s1 > s2) ? s1 : s2;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      car[0] <= '{op: item.op, wlev: item.write_level, x: item.texel_x, y: item.texel_y,
                  word: item.texel_word, u: item.tex_u, v: item.tex_v,
                  dzero: ((item.du_u | item.du_v | item.dv_u | item.dv_v) == 32'd0)};
      for (int i = 1; i < NS; i++) car[i] <= car[i-1];
      d0[0] <= item.du_u;
      d0[1] <= item.du_v;
      d0[2] <= item.dv_u;
      d0[3] <= item.dv_v;
      for (int i = 0; i < 4; i++) sq[i] <= 64'(mag32(d0[i])) * 64'(mag32(d0[i]));
      s2r <= (smax < 64'd4295) ? 64'd4295 : smax;
      s3  <= s2r;
      for (int g = 0; g < 8; g++) begin
        gnz[g]  <= |s2r[8*g +: 8];
        gpos[g] <= msb8(s2r[8*g +: 8]);
      end
    end
  end

  // stage 4: normalise to a q1.31 mantissa
  logic [2:0]  gsel;
  logic [5:0]  nn;
  logic [63:0] shv;
  always_comb begin
    gsel = 3'd0;
    for (int g = 0; g < 8; g++) begin
      if (gnz[g]) gsel = 3'(g);
    end
    nn = {gsel, gpos[gsel]};
    if (nn >= 6'd31) shv = s3 >> (nn - 6'd31);
    else shv = s3 << (6'd31 - nn);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      n4 <= nn;
      m4 <= shv[31:0];
    end
  end

  // stages 5 to 11: one fraction bit per squaring
  for (genvar j = 0; j < 7; j++) begin : g_log
    logic [31:0] m_in;
    logic [6:0]  b_in;
    logic [5:0]  n_in;
    logic [63:0] prod;
    logic [32:0] mm;
    if (j == 0) begin : g_first
      assign m_in = m4;
      assign b_in = 7'd0;
      assign n_in = n4;
    end else begin : g_next
      assign m_in = lm[j-1];
      assign b_in = lb[j-1];
      assign n_in = ln[j-1];
    end
    assign prod = 64'(m_in) * 64'(m_in);
    assign mm   = prod[63:31];
    always_ff @(posedge clk) begin
      if (advance) begin
        lm[j] <= mm[32] ? mm[32:1] : mm[31:0];
        lb[j] <= b_in | (mm[32] ? (7'd1 << (6 - j)) : 7'd0);
        ln[j] <= n_in;
      end
    end
  end

  // classification of the last stage
  carry_t             c;
  logic [3:0]         levels, finest;
  logic signed [15:0] lod, lodc, fin256;
  logic               fin;
  logic [KW-1:0]      k0;
  always_comb begin
    c = car[NS-1];
    if (cfg.level_count == 4'd0) levels = 4'd1;
    else if (32'(cfg.level_count) > MAX_LEVELS) levels = 4'(MAX_LEVELS);
    else levels = cfg.level_count;
    finest = levels - 4'd1;
    lod    = 16'sd4096 - $signed({3'b000, ln[6], lb[6]}) - 16'(cfg.lod_bias);
    fin256 = $signed({4'b0000, finest, 8'b0000_0000});
    fin    = !cfg.filter_mode || c.dzero || (lod >= fin256);
    lodc   = (lod < 16'sd0) ? 16'sd0 : lod;
    k0     = fin ? KW'(finest) : lodc[8 +: KW];
    qd.op    = c.op;
    qd.wr_ok = (32'(c.wlev) < MAX_LEVELS) && ((c.x >> c.wlev) == 7'd0)
               && ((c.y >> c.wlev) == 7'd0);
    qd.wlev  = c.wlev;
    qd.x     = c.x;
    qd.y     = c.y;
    qd.word  = c.word;
    qd.u     = c.u;
    qd.v     = c.v;
    qd.k0    = k0;
    qd.k1    = fin ? k0 : k0 + 1'b1;
    qd.frac  = fin ? 8'd0 : lodc[7:0];
    qd.used  = fin;
  end

  assign q_push = pv[NS-1] && !q_full;
endmodule

>>> rtl/msamp_back.sv
// msamp_back: texel store, read sequencer over two ports and the filter pipeline
// with its result queue; depends on msamp_pkg and msamp_fifo
module msamp_back #(
  parameter int MAX_LEVELS   = msamp_pkg::MAX_LEVELS,
  parameter int CHANNEL_BITS = msamp_pkg::CHANNEL_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  msamp_pkg::qitem_t  qh,
  input  logic               q_empty,
  output logic               q_pop,
  output msamp_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_stall,
  output msamp_pkg::bstat_t  stat
);
  localparam int STORE_DEPTH = ((1 << (2 * MAX_LEVELS)) - 1) / 3;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CB = CHANNEL_BITS;
  localparam int TW = 3 * CB;
  localparam int CW = MAX_LEVELS;
  localparam int KW = msamp_pkg::KW;
  localparam int IW = msamp_pkg::IW;

  typedef enum logic [1:0] {ST_IDLE = 2'b01, ST_READ = 2'b10} state_t;

  function automatic logic [AW-1:0] taddr(input logic [KW-1:0] k,
                                          input logic [CW-1:0] x, input logic [CW-1:0] y);
    logic [31:0] b;
    b = msamp_pkg::lvl_base(k);
    return AW'(b) + (AW'(y) << k) + AW'(x);
  endfunction

  function automatic logic [CB-1:0] mix(input logic [15:0] t,
                                        input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB+17:0] s;
    s = (CB+18)'(a) * (CB+18)'(17'h10000 - 17'(t)) + (CB+18)'(b) * (CB+18)'(t)
        + (CB+18)'(32768);
    return s[16 +: CB];
  endfunction

  function automatic logic [CB-1:0] chan(input logic [TW-1:0] w, input int c);
    return w[(2 - c) * CB +: CB];
  endfunction

  logic [TW-1:0] mem [STORE_DEPTH];
  state_t        state;
  logic [1:0]    phase;
  logic [IW-1:0] inflight;
  logic          start, sample_go, wr_go, out_full, out_pop;

  // coordinates and addresses of both levels from the queue head
  logic [KW-1:0] kk;
  logic [47:0]   pu, pw;
  logic [CW-1:0] mk, cx0, cx1, cy0, cy1;
  logic [15:0]   cfx [2], cfy [2];
  logic [AW-1:0] adr [8];
  logic [AW-1:0] waddr, ra, rb;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      kk  = (l == 0) ? qh.k0 : qh.k1;
      pu  = {16'd0, qh.u} << kk;
      pw  = {16'd0, qh.v} << kk;
      mk  = CW'((32'd1 << kk) - 32'd1);
      cx0 = pu[16 +: CW] & mk;
      cy0 = pw[16 +: CW] & mk;
      cx1 = (cx0 + 1'b1) & mk;
      cy1 = (cy0 + 1'b1) & mk;
      cfx[l] = pu[15:0];
      cfy[l] = pw[15:0];
      adr[4*l]   = taddr(kk, cx0, cy0);
      adr[4*l+1] = taddr(kk, cx1, cy0);
      adr[4*l+2] = taddr(kk, cx0, cy1);
      adr[4*l+3] = taddr(kk, cx1, cy1);
    end
    waddr = taddr(KW'(qh.wlev), CW'(qh.x), CW'(qh.y));
  end

  assign start = (state == ST_IDLE) && !q_empty
                 && ((qh.op == msamp_pkg::OP_WRITE) || (inflight < IW'(msamp_pkg::OUT_DEPTH)));
  assign q_pop     = start;
  assign sample_go = start && (qh.op == msamp_pkg::OP_SAMPLE);
  assign wr_go     = start && (qh.op == msamp_pkg::OP_WRITE) && qh.wr_ok;

  logic [AW-1:0] ladr [8];
  logic [15:0]   lfx [2], lfy [2];
  logic [7:0]    lfrac;
  logic          lused;

  assign ra = wr_go ? waddr : ((state == ST_IDLE) ? adr[0] : ladr[2]);
  assign rb = (state == ST_IDLE) ? adr[1] : ladr[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= 2'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (sample_go) begin
            state <= ST_READ;
            phase <= 2'd1;
          end
        end
        ST_READ: begin
          phase <= phase + 2'd1;
          if (phase == 2'd3) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sample_go) begin
      for (int i = 0; i < 8; i++) ladr[i] <= adr[i];
      for (int l = 0; l < 2; l++) begin
        lfx[l] <= cfx[l];
        lfy[l] <= cfy[l];
      end
      lfrac <= qh.frac;
      lused <= qh.used;
    end else if (state == ST_READ) begin
      for (int i = 0; i < 6; i++) ladr[i] <= ladr[i+2];
    end
  end

  // texel store: port a reads or writes, port b reads
  logic [TW-1:0] rda, rdb;
  always_ff @(posedge clk) begin
    if (wr_go) mem[waddr] <= {qh.word[32 +: CB], qh.word[16 +: CB], qh.word[0 +: CB]};
    rda <= mem[ra];
    rdb <= mem[rb];
  end

  logic       rd_vld;
  logic [1:0] rd_ph;
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      rd_ph  <= 2'd0;
    end else begin
      rd_vld <= sample_go || (state == ST_READ);
      rd_ph  <= (state == ST_READ) ? phase : 2'd0;
    end
  end

  logic [TW-1:0] tex [6];
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      case (rd_ph)
        2'd0: begin
          tex[0] <= rda;
          tex[1] <= rdb;
        end
        2'd1: begin
          tex[2] <= rda;
          tex[3] <= rdb;
        end
        2'd2: begin
          tex[4] <= rda;
          tex[5] <= rdb;
        end
        default: ;
      endcase
    end
  end

  // filter: rows along u, then v, then the blend of both levels
  logic [TW-1:0] t8 [8];
  always_comb begin
    for (int i = 0; i < 6; i++) t8[i] = tex[i];
    t8[6] = rda;
    t8[7] = rdb;
  end

  logic          c1v, c2v;
  logic [CB-1:0] rowv [2][2][3];
  logic [CB-1:0] colv [2][3];
  logic [15:0]   c1fy [2];
  logic [7:0]    c1f, c2f;
  logic          c1u, c2u;
  always_ff @(posedge clk) begin
    if (rst) begin
      c1v <= 1'b0;
      c2v <= 1'b0;
    end else begin
      c1v <= rd_vld && (rd_ph == 2'd3);
      c2v <= c1v;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      for (int r = 0; r < 2; r++) begin
        for (int c = 0; c < 3; c++) begin
          rowv[l][r][c] <= mix(lfx[l], chan(t8[4*l+2*r], c), chan(t8[4*l+2*r+1], c));
        end
      end
      for (int c = 0; c < 3; c++) colv[l][c] <= mix(c1fy[l], rowv[l][0][c], rowv[l][1][c]);
      c1fy[l] <= lfy[l];
    end
    c1f <= lfrac;
    c1u <= lused;
    c2f <= c1f;
    c2u <= c1u;
  end

  logic [CB+9:0]        bl [3];
  msamp_pkg::result_t   res;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bl[c] = (CB+10)'(colv[0][c]) * (CB+10)'(9'd256 - 9'(c2f))
              + (CB+10)'(colv[1][c]) * (CB+10)'(c2f) + (CB+10)'(128);
    end
    res.red         = 16'(bl[0][8 +: CB]);
    res.green       = 16'(bl[1][8 +: CB]);
    res.blue        = 16'(bl[2][8 +: CB]);
    res.used_finest = c2u;
  end

  logic out_empty;
  msamp_fifo #(.T(msamp_pkg::result_t), .DEPTH(msamp_pkg::OUT_DEPTH)) u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (c2v),
    .wdata (res),
    .pop   (out_pop),
    .rdata (result),
    .full  (out_full),
    .empty (out_empty)
  );

  assign result_valid = !out_empty;
  assign out_pop      = !out_empty && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (sample_go && !out_pop) begin
      inflight <= inflight + 1'b1;
    end else if (out_pop && !sample_go) begin
      inflight <= inflight - 1'b1;
    end
  end

  assign stat.inflight = inflight | (out_full ? IW'(msamp_pkg::OUT_DEPTH) : '0);
endmodule

>>> rtl/mipmap_texture_sampler.sv
// mipmap_texture_sampler: top level with configuration registers, the lod front
// part, the queue and the texel back part; depends on msamp_pkg and all modules
//
//  channel   | handshake                 | word
//  item      | item_valid / item_stall   | msamp_pkg::item_t
//  result    | result_valid / result_stall | msamp_pkg::result_t
//  config    | psel penable pwrite pready | pwdata, paddr, prdata
//
// a sample reads its eight texels in the back part, two texel reads a cycle on the
// two memory ports, and the next queue entry waits for those reads; a write uses port a
// the front lod pipeline takes a word every cycle while the queue has room
// reset is synchronous and clears control state; the texel store is not cleared
// item_stall rises when the last lod stage cannot enter the full queue
module mipmap_texture_sampler #(
  parameter int MAX_LEVELS   = msamp_pkg::MAX_LEVELS,
  parameter int CHANNEL_BITS = msamp_pkg::CHANNEL_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  msamp_pkg::item_t   item,
  input  logic               item_valid,
  output logic               item_stall,
  output msamp_pkg::result_t result,
  output logic               result_valid,
  input  logic               result_stall,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  msamp_pkg::cfg_t   cfg;
  msamp_pkg::qitem_t qd, qh;
  msamp_pkg::bstat_t bstat;
  logic              q_push, q_pop, q_full, q_empty;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_mode <= 1'b1;
      cfg.lod_bias    <= 12'sd0;
      cfg.level_count <= 4'd8;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        msamp_pkg::REG_FILTER_MODE: cfg.filter_mode <= pwdata[0];
        msamp_pkg::REG_LOD_BIAS:    cfg.lod_bias    <= pwdata[11:0];
        msamp_pkg::REG_LEVEL_COUNT: cfg.level_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      msamp_pkg::REG_FILTER_MODE: prdata = {31'd0, cfg.filter_mode};
      msamp_pkg::REG_LOD_BIAS:    prdata = {20'd0, cfg.lod_bias};
      msamp_pkg::REG_LEVEL_COUNT: prdata = {28'd0, cfg.level_count};
      default:                    prdata = 32'd0;
    endcase
  end

  msamp_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cfg        (cfg),
    .qd         (qd),
    .q_push     (q_push),
    .q_full     (q_full)
  );

  msamp_fifo #(.T(msamp_pkg::qitem_t), .DEPTH(msamp_pkg::QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (qd),
    .pop   (q_pop),
    .rdata (qh),
    .full  (q_full),
    .empty (q_empty)
  );

  msamp_back #(.MAX_LEVELS(MAX_LEVELS), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .qh           (qh),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (bstat)
  );

`ifndef SYNTHESIS
  a_queue_overflow: assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("queue pushed while full");
  a_queue_underflow: assert property (@(posedge clk) disable iff (rst) q_empty |-> !q_pop)
    else $error("queue popped while empty");
  a_credit: assert property (@(posedge clk) disable iff (rst)
      bstat.inflight <= 3'(msamp_pkg::OUT_DEPTH))
    else $error("samples in flight exceed result queue");
`endif
endmodule
